@@ hw/rtl/opp_pkg.sv @@
// opp_pkg: shared types, symbol and result codes, and the precedence table
// of the operator-precedence expression parser. No dependencies.
`default_nettype none

package opp_pkg;

    localparam int unsigned OPP_STACK_DEPTH = 32;
    localparam int unsigned SYM_W           = 4;
    localparam int unsigned MAX_REDUCTIONS  = 4;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [3:0]       t_rule;

    // stack symbols: terminals share the token class coding
    localparam t_sym SYM_NE   = 4'd9;
    localparam t_sym SYM_LPAR = 4'd10;
    localparam t_sym SYM_RPAR = 4'd11;
    localparam t_sym SYM_OPND = 4'd12;
    localparam t_sym SYM_END  = 4'd13;
    localparam t_sym SYM_E    = 4'd14;
    localparam t_sym SYM_MARK = 4'd15;

    localparam t_rule RULE_OPND   = 4'd0;
    localparam t_rule RULE_PARENS = 4'd1;
    localparam t_rule RULE_MUL    = 4'd2;

    typedef enum logic [1:0] {
        REL_V,
        REL_M,
        REL_R,
        REL_E
    } t_rel;

    typedef enum logic [2:0] {
        KIND_REDUCE   = 3'd0,
        KIND_SHIFT    = 3'd1,
        KIND_ACCEPT   = 3'd2,
        KIND_SYNTAX   = 3'd3,
        KIND_UNDEF    = 3'd4,
        KIND_OVERFLOW = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_rule rule;
        logic  last;
    } t_result;

    // row: top terminal, column: incoming token
    localparam t_rel PREC_TABLE [0:13][0:13] = '{
        '{REL_V, REL_V, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_M, REL_V, REL_M, REL_V},
        '{REL_V, REL_V, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_E, REL_E, REL_E,
          REL_E, REL_E, REL_E, REL_M, REL_V, REL_M, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_M, REL_M, REL_M,
          REL_M, REL_M, REL_M, REL_M, REL_R, REL_M, REL_E},
        '{REL_V, REL_V, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_R, REL_V, REL_E, REL_V},
        '{REL_V, REL_V, REL_V, REL_V, REL_V, REL_V, REL_V,
          REL_V, REL_V, REL_V, REL_R, REL_V, REL_E, REL_V},
        '{REL_M, REL_M, REL_M, REL_M, REL_M, REL_M, REL_M,
          REL_M, REL_M, REL_M, REL_M, REL_E, REL_M, REL_E}
    };

    // classes above end of expression count as end
    function automatic t_sym clamp_sym(input t_sym s);
        return (s > SYM_END) ? SYM_END : s;
    endfunction

    function automatic t_rel prec_rel(input t_sym a, input t_sym b);
        t_sym ra;
        t_sym rb;
        ra = clamp_sym(a);
        rb = clamp_sym(b);
        return PREC_TABLE[ra][rb];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/opp_stack_ram.sv @@
// opp_stack_ram: symbol stack memory, one write port and two read ports
// with registered read data. Depends on opp_pkg.
`default_nettype none

module opp_stack_ram
    import opp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = OPP_STACK_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(STACK_DEPTH)-1:0] i_waddr,
    input  wire t_sym                           i_wdata,
    input  wire logic [$clog2(STACK_DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(STACK_DEPTH)-1:0] i_raddr_b,
    output      t_sym                           o_rdata_a,
    output      t_sym                           o_rdata_b
);

    t_sym r_mem [STACK_DEPTH];
    t_sym r_rdata_a;
    t_sym r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

@@ hw/rtl/opp_ctrl.sv @@
// opp_ctrl: parse sequencer. Keeps the stack count and the top two stack
// entries, reads deeper entries from opp_stack_ram and writes back pushes
// and reductions. Depends on opp_pkg.
`default_nettype none

module opp_ctrl
    import opp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = OPP_STACK_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [3:0]                     i_token_class,
    input  wire logic                           i_undefined_name,
    input  wire logic                           i_slot_free,
    output      logic                           o_res_valid,
    output      t_result                        o_res,
    output      logic                           o_we,
    output      logic [$clog2(STACK_DEPTH)-1:0] o_waddr,
    output      t_sym                           o_wdata,
    output      logic [$clog2(STACK_DEPTH)-1:0] o_raddr_a,
    output      logic [$clog2(STACK_DEPTH)-1:0] o_raddr_b,
    input  wire t_sym                           i_rdata_a,
    input  wire t_sym                           i_rdata_b
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_REFILL,
        S_PUSH
    } t_state;

    t_state          r_state,       n_state;
    logic [CW-1:0]   r_cnt,         n_cnt;
    t_sym            r_w0,          n_w0;
    t_sym            r_w1,          n_w1;
    t_sym            r_tok,         n_tok;
    logic            r_undef,       n_undef;
    logic [2:0]      r_k,           n_k;
    logic            r_from_refill, n_from_refill;
    logic [1:0]      r_push_left,   n_push_left;
    logic [AW-1:0]   r_push_addr,   n_push_addr;
    t_sym            r_push_q0,     n_push_q0;
    t_sym            r_push_q1,     n_push_q1;
    logic            r_za,          n_za;
    logic            r_zb,          n_zb;

    logic [CW-1:0] cnt_m1, cnt_m2, cnt_m3, cnt_m4, cnt_p1;
    t_sym          q3, q4, top_a;
    t_rel          rel;
    logic          top_is_e, ge2, ge4;
    logic          m_par, m_op, m_opnd, ovf;
    logic [CW:0]   need;

    assign cnt_m1 = r_cnt - CW'(1);
    assign cnt_m2 = r_cnt - CW'(2);
    assign cnt_m3 = r_cnt - CW'(3);
    assign cnt_m4 = r_cnt - CW'(4);
    assign cnt_p1 = r_cnt + CW'(1);

    // bottom entry is never written and always reads as end marker
    assign q3 = r_za ? SYM_END : i_rdata_a;
    assign q4 = r_zb ? SYM_END : i_rdata_b;

    assign top_is_e = (r_w0 == SYM_E);
    assign top_a    = top_is_e ? r_w1 : r_w0;
    assign rel      = prec_rel(top_a, r_tok);
    assign ge2      = (r_cnt >= CW'(2));
    assign ge4      = (r_cnt >= CW'(4));

    assign m_par  = ge4 && (q4 == SYM_MARK) && (q3 == SYM_LPAR)
                    && (r_w1 == SYM_E) && (r_w0 == SYM_RPAR);
    assign m_op   = ge4 && (q4 == SYM_MARK) && (q3 == SYM_E)
                    && (r_w0 == SYM_E) && (r_w1 <= SYM_NE);
    assign m_opnd = ge2 && (r_w1 == SYM_MARK) && (r_w0 == SYM_OPND);

    assign need = {1'b0, r_cnt} + ((rel == REL_M) ? (CW + 1)'(2) : (CW + 1)'(1));
    assign ovf  = (need > DEPTH_W);

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EVAL);
    assign o_raddr_a   = (r_state == S_REFILL) ? cnt_m2[AW-1:0] : cnt_m3[AW-1:0];
    assign o_raddr_b   = cnt_m4[AW-1:0];
    assign n_za        = (o_raddr_a == '0);
    assign n_zb        = (o_raddr_b == '0);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_w0          = r_w0;
        n_w1          = r_w1;
        n_tok         = r_tok;
        n_undef       = r_undef;
        n_k           = r_k;
        n_from_refill = r_from_refill;
        n_push_left   = r_push_left;
        n_push_addr   = r_push_addr;
        n_push_q0     = r_push_q0;
        n_push_q1     = r_push_q1;
        o_we          = 1'b0;
        o_waddr       = cnt_m2[AW-1:0];
        o_wdata       = SYM_E;
        o_res.kind    = KIND_SHIFT;
        o_res.rule    = RULE_OPND;
        o_res.last    = 1'b1;

        // result of the current evaluation step
        if (r_tok == SYM_OPND && r_undef) begin
            o_res.kind = KIND_UNDEF;
        end else begin
            case (rel)
                REL_V: begin
                    if (!(m_par || m_op || m_opnd) || r_k == 3'(MAX_REDUCTIONS)) begin
                        o_res.kind = KIND_SYNTAX;
                    end else begin
                        o_res.kind = KIND_REDUCE;
                        o_res.last = 1'b0;
                        if (m_par) begin
                            o_res.rule = RULE_PARENS;
                        end else if (m_op) begin
                            o_res.rule = r_w1 + RULE_MUL;
                        end else begin
                            o_res.rule = RULE_OPND;
                        end
                    end
                end
                REL_E: begin
                    o_res.kind = (top_a == SYM_END && r_tok == SYM_END)
                                 ? KIND_ACCEPT : KIND_SYNTAX;
                end
                default: begin
                    o_res.kind = ovf ? KIND_OVERFLOW : KIND_SHIFT;
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_tok         = clamp_sym(i_token_class);
                    n_undef       = i_undefined_name;
                    n_k           = '0;
                    n_from_refill = 1'b0;
                    n_state       = S_FETCH;
                end
            end
            S_REFILL: begin
                n_from_refill = 1'b1;
                n_state       = S_FETCH;
            end
            S_FETCH: begin
                if (r_from_refill) begin
                    n_w1 = q3;
                end
                n_from_refill = 1'b0;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (i_slot_free) begin
                    if (o_res.kind == KIND_REDUCE) begin
                        o_we = 1'b1;
                        n_k  = r_k + 3'd1;
                        n_w0 = SYM_E;
                        if (o_res.rule == RULE_OPND) begin
                            o_waddr = cnt_m2[AW-1:0];
                            n_cnt   = cnt_m1;
                            n_w1    = q3;
                            n_state = S_FETCH;
                        end else begin
                            o_waddr = cnt_m4[AW-1:0];
                            n_cnt   = cnt_m3;
                            n_state = S_REFILL;
                        end
                    end else if (o_res.kind == KIND_SHIFT) begin
                        o_we = 1'b1;
                        n_w0 = r_tok;
                        if (rel == REL_M) begin
                            n_cnt   = r_cnt + CW'(2);
                            o_wdata = SYM_MARK;
                            n_state = S_PUSH;
                            if (top_is_e) begin
                                o_waddr     = cnt_m1[AW-1:0];
                                n_push_left = 2'd2;
                                n_push_addr = r_cnt[AW-1:0];
                                n_push_q0   = SYM_E;
                                n_push_q1   = r_tok;
                                n_w1        = SYM_E;
                            end else begin
                                o_waddr     = r_cnt[AW-1:0];
                                n_push_left = 2'd1;
                                n_push_addr = cnt_p1[AW-1:0];
                                n_push_q0   = r_tok;
                                n_w1        = SYM_MARK;
                            end
                        end else begin
                            o_waddr = r_cnt[AW-1:0];
                            o_wdata = r_tok;
                            n_cnt   = cnt_p1;
                            n_w1    = r_w0;
                            n_state = S_IDLE;
                        end
                    end else begin
                        // accept or error: back to the initial stack
                        n_cnt   = CW'(1);
                        n_w0    = SYM_END;
                        n_state = S_IDLE;
                    end
                end
            end
            S_PUSH: begin
                o_we        = 1'b1;
                o_waddr     = r_push_addr;
                o_wdata     = r_push_q0;
                n_push_addr = r_push_addr + AW'(1);
                n_push_q0   = r_push_q1;
                n_push_left = r_push_left - 2'd1;
                if (r_push_left == 2'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= CW'(1);
            r_w0          <= SYM_END;
            r_k           <= '0;
            r_from_refill <= 1'b0;
            r_push_left   <= '0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_w0          <= n_w0;
            r_k           <= n_k;
            r_from_refill <= n_from_refill;
            r_push_left   <= n_push_left;
        end
        r_w1        <= n_w1;
        r_tok       <= n_tok;
        r_undef     <= n_undef;
        r_push_addr <= n_push_addr;
        r_push_q0   <= n_push_q0;
        r_push_q1   <= n_push_q1;
        r_za        <= n_za;
        r_zb        <= n_zb;
    end

endmodule

`default_nettype wire

@@ hw/rtl/operator_precedence_expr_parser.sv @@
// operator_precedence_expr_parser: top level, sequencer, stack memory and
// result output register. Depends on opp_pkg, opp_ctrl, opp_stack_ram.
//
// Shift-reduce operator-precedence parser. One token is taken at a time;
// it yields up to four reduction transactions followed by one final
// transaction (shifted, accepted or an error) marked by o_last. The
// symbol stack lives in a single-write, dual-read memory with registered
// read data, and the top two entries are kept in registers. An accepted
// token passes through the fetch and evaluate states to its first result;
// a shift that pushes a handle marker adds memory writes in the push state.
// Each operand reduction returns through fetch, and each parenthesis or
// operator reduction through refill and fetch, for the memory reads.
// Output stalls hold the sequencer in evaluate. No clearing pass is
// needed after reset: the bottom of the stack is supplied by logic.
`default_nettype none

module operator_precedence_expr_parser
    import opp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = OPP_STACK_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_ready,
    input  wire logic [3:0] i_token_class,
    input  wire logic       i_undefined_name,
    output      logic       o_valid,
    input  wire logic       i_ready,
    output      logic [2:0] o_kind,
    output      logic [3:0] o_rule,
    output      logic       o_last
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic          slot_free;
    logic          res_valid;
    t_result       res;
    logic          we;
    logic [AW-1:0] waddr;
    t_sym          wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    t_sym          rdata_a;
    t_sym          rdata_b;

    logic          r_out_valid;
    t_result       r_out;

    assign slot_free = !r_out_valid || i_ready;

    opp_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_token_class    (i_token_class),
        .i_undefined_name (i_undefined_name),
        .i_slot_free      (slot_free),
        .o_res_valid      (res_valid),
        .o_res            (res),
        .o_we             (we),
        .o_waddr          (waddr),
        .o_wdata          (wdata),
        .o_raddr_a        (raddr_a),
        .o_raddr_b        (raddr_b),
        .i_rdata_a        (rdata_a),
        .i_rdata_b        (rdata_b)
    );

    opp_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && slot_free) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out.kind;
    assign o_rule  = r_out.rule;
    assign o_last  = r_out.last;

endmodule

`default_nettype wire

@@ hw/rtl/opp_checker.sv @@
// opp_checker: port-level assertions for operator_precedence_expr_parser,
// attached by the bind below. Depends on opp_pkg.
`default_nettype none

module opp_checker
    import opp_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_kind,
    input wire logic [3:0] o_rule,
    input wire logic       o_last
);

    // a stalled result holds
    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_rule)
                                && $stable(o_last);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // only reductions are followed by more results for the same token
    property p_last_kind;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind != KIND_REDUCE));
    endproperty
    a_last_kind: assert property (p_last_kind)
        else $error("last flag does not match result kind");

    property p_rule_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_REDUCE |-> o_rule == RULE_OPND;
    endproperty
    a_rule_zero: assert property (p_rule_zero)
        else $error("rule set on a non-reduction result");

    // one token in flight at a time
    property p_one_token;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready;
    endproperty
    a_one_token: assert property (p_one_token)
        else $error("token accepted while another is in progress");

endmodule

bind operator_precedence_expr_parser opp_checker u_opp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_kind  (o_kind),
    .o_rule  (o_rule),
    .o_last  (o_last)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking testbench for operator_precedence_expr_parser, with a
// token-level shift-reduce parser model, a queued token driver and a result monitor.
// Depends on opp_pkg and the parser RTL.

module tb_top;
    import opp_pkg::*;

    localparam int unsigned STACK_DEPTH    = OPP_STACK_DEPTH;
    localparam int unsigned TOTAL_TOKENS   = 270;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int          NO_RULE        = -1;

    localparam logic [3:0] TK_MUL    = 4'd0;
    localparam logic [3:0] TK_DIV    = 4'd1;
    localparam logic [3:0] TK_ADD    = 4'd2;
    localparam logic [3:0] TK_SUB    = 4'd3;
    localparam logic [3:0] TK_LT     = 4'd4;
    localparam logic [3:0] TK_LE     = 4'd5;
    localparam logic [3:0] TK_GT     = 4'd6;
    localparam logic [3:0] TK_GE     = 4'd7;
    localparam logic [3:0] TK_EQ     = 4'd8;
    localparam logic [3:0] TK_NE     = 4'd9;
    localparam logic [3:0] TK_LPAR   = 4'd10;
    localparam logic [3:0] TK_RPAR   = 4'd11;
    localparam logic [3:0] TK_OPND   = 4'd12;
    localparam logic [3:0] TK_END    = 4'd13;
    localparam logic [3:0] TK_SPARE0 = 4'd14;
    localparam logic [3:0] TK_SPARE1 = 4'd15;

    typedef struct packed {
        logic [3:0] cls;
        logic       undef;
    } t_token;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [3:0] i_token_class;
    logic       i_undefined_name;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_kind;
    logic [3:0] o_rule;
    logic       o_last;

    t_token      token_queue[$];
    t_result     expected_results[$];
    t_token      next_token;
    logic [3:0]  sym_stack [0:STACK_DEPTH-1];
    int unsigned sym_count;

    int unsigned total_tokens;
    int unsigned sent_count;
    int unsigned result_count;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned kind_seen [0:7];
    bit          token_taken;
    bit          timed_out;

    operator_precedence_expr_parser #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_token_class   (i_token_class),
        .i_undefined_name(i_undefined_name),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_rule          (o_rule),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_stack();
        sym_stack[0] = SYM_END;
        sym_count = 1;
    endfunction

    function automatic void queue_result(input t_kind kind, input t_rule rule, input logic last);
        t_result r;
        r.kind = kind;
        r.rule = rule;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // a: top terminal on the stack, b: incoming token, both already clamped
    function automatic t_rel precedence(input logic [3:0] a, input logic [3:0] b);
        t_rel rel;
        if (a <= TK_DIV) begin
            rel = (b == TK_LPAR || b == TK_OPND) ? REL_M : REL_V;
        end else if (a <= TK_SUB) begin
            rel = (b <= TK_DIV || b == TK_LPAR || b == TK_OPND) ? REL_M : REL_V;
        end else if (a <= TK_NE) begin
            if (b <= TK_SUB || b == TK_LPAR || b == TK_OPND) begin
                rel = REL_M;
            end else if (b <= TK_NE) begin
                rel = REL_E;
            end else begin
                rel = REL_V;
            end
        end else if (a == TK_LPAR) begin
            rel = (b == TK_RPAR) ? REL_R : ((b == TK_END) ? REL_E : REL_M);
        end else if (a == TK_RPAR || a == TK_OPND) begin
            rel = (b == TK_LPAR) ? REL_R : ((b == TK_OPND) ? REL_E : REL_V);
        end else begin
            rel = (b == TK_RPAR || b == TK_END) ? REL_E : REL_M;
        end
        return rel;
    endfunction

    function automatic int handle_rule();
        int unsigned n;
        n = sym_count;
        if (n >= 4) begin
            if (sym_stack[n-4] == SYM_MARK && sym_stack[n-3] == TK_LPAR &&
                sym_stack[n-2] == SYM_E && sym_stack[n-1] == TK_RPAR) begin
                return RULE_PARENS;
            end
            if (sym_stack[n-4] == SYM_MARK && sym_stack[n-3] == SYM_E &&
                sym_stack[n-1] == SYM_E && sym_stack[n-2] <= TK_NE) begin
                return int'(sym_stack[n-2]) - int'(TK_MUL) + int'(RULE_MUL);
            end
        end
        if (n >= 2 && sym_stack[n-2] == SYM_MARK && sym_stack[n-1] == TK_OPND) begin
            return RULE_OPND;
        end
        return NO_RULE;
    endfunction

    // reductions the token triggers, then its final result
    function automatic void parse_token(input logic [3:0] cls, input logic undef);
        logic [3:0]  tok;
        logic [3:0]  top;
        int unsigned t;
        int unsigned i;
        int unsigned n_reduce;
        int          rule;
        t_rel        rel;
        bit          done;
        tok = (cls > TK_END) ? TK_END : cls;
        if (tok == TK_OPND && undef) begin
            clear_stack();
            queue_result(KIND_UNDEF, '0, 1'b1);
            return;
        end
        n_reduce = 0;
        done = 1'b0;
        while (!done) begin
            t = sym_count - 1;
            while (t > 0 && sym_stack[t] >= SYM_E) t--;
            top = sym_stack[t];
            rel = precedence(top, tok);
            if (rel == REL_V) begin
                rule = handle_rule();
                if (rule == NO_RULE || n_reduce >= MAX_REDUCTIONS) begin
                    clear_stack();
                    queue_result(KIND_SYNTAX, '0, 1'b1);
                    done = 1'b1;
                end else begin
                    sym_count = sym_count - ((rule == RULE_OPND) ? 2 : 4);
                    sym_stack[sym_count] = SYM_E;
                    sym_count++;
                    queue_result(KIND_REDUCE, t_rule'(rule), 1'b0);
                    n_reduce++;
                end
            end else if (rel == REL_E) begin
                queue_result((top == TK_END && tok == TK_END) ? KIND_ACCEPT : KIND_SYNTAX,
                             '0, 1'b1);
                clear_stack();
                done = 1'b1;
            end else if (sym_count + ((rel == REL_M) ? 2 : 1) > STACK_DEPTH) begin
                clear_stack();
                queue_result(KIND_OVERFLOW, '0, 1'b1);
                done = 1'b1;
            end else begin
                if (rel == REL_M) begin
                    for (i = sym_count; i > t + 1; i--) sym_stack[i] = sym_stack[i-1];
                    sym_stack[t+1] = SYM_MARK;
                    sym_count++;
                end
                sym_stack[sym_count] = tok;
                sym_count++;
                queue_result(KIND_SHIFT, '0, 1'b1);
                done = 1'b1;
            end
        end
    endfunction

    function automatic void add_token(input logic [3:0] cls, input logic undef);
        t_token tk;
        tk.cls = cls;
        tk.undef = undef;
        token_queue.push_back(tk);
    endfunction

    // well-formed expression ending in end; relational operators once per paren level
    function automatic void add_expression(input int unsigned max_depth,
                                           input int unsigned budget);
        int unsigned depth;
        int unsigned emitted;
        bit          want_operand;
        bit          done;
        bit          rel_used [0:15];
        logic [3:0]  op;
        depth = 0;
        emitted = 0;
        want_operand = 1'b1;
        done = 1'b0;
        rel_used[0] = 1'b0;
        while (!done) begin
            if (want_operand) begin
                if (depth < max_depth && $urandom_range(3) == 0) begin
                    add_token(TK_LPAR, $urandom_range(1));
                    depth++;
                    rel_used[depth] = 1'b0;
                end else begin
                    add_token(TK_OPND, $urandom_range(39) == 0);
                    want_operand = 1'b0;
                end
            end else if (emitted >= budget || (depth > 0 && $urandom_range(3) == 0)) begin
                if (depth > 0) begin
                    add_token(TK_RPAR, $urandom_range(1));
                    depth--;
                end else begin
                    add_token(TK_END, $urandom_range(1));
                    done = 1'b1;
                end
            end else begin
                if (rel_used[depth]) begin
                    op = $urandom_range(TK_SUB, TK_MUL);
                end else begin
                    op = $urandom_range(TK_NE, TK_MUL);
                end
                if (op >= TK_LT) rel_used[depth] = 1'b1;
                add_token(op, $urandom_range(1));
                want_operand = 1'b1;
            end
            emitted++;
        end
    endfunction

    function automatic void note_mismatch(input bit have_exp, input t_result want,
                                          input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (have_exp) begin
                $display("%0t mismatch on result %0d: expected kind %0d rule %0d last %0d, got kind %0d rule %0d last %0d",
                         $time, result_count, want.kind, want.rule, want.last,
                         got.kind, got.rule, got.last);
            end else begin
                $display("%0t unexpected result %0d: kind %0d rule %0d last %0d",
                         $time, result_count, got.kind, got.rule, got.last);
            end
        end
    endfunction

    // driver: one token transaction at a time, idling per phase
    always @(negedge i_clk) begin
        case ((sent_count * 4) / total_tokens)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 72;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 72;
            end
            default: begin
                send_idle_pct = 11;
                stall_pct = 11;
            end
        endcase
        if (i_rst_n) begin
            if (!i_valid || token_taken) begin
                if (token_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_token = token_queue.pop_front();
                    i_token_class <= next_token.cls;
                    i_undefined_name <= next_token.undef;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on accepted tokens, check accepted results
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        token_taken = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                parse_token(i_token_class, i_undefined_name);
                sent_count++;
                token_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                got.kind = t_kind'(o_kind);
                got.rule = o_rule;
                got.last = o_last;
                if (!$isunknown(o_kind)) kind_seen[o_kind]++;
                if (expected_results.size() == 0) begin
                    want = '0;
                    note_mismatch(1'b0, want, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) note_mismatch(1'b1, want, got);
                end
                result_count++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
    end

    initial begin
        int unsigned sel;
        int unsigned start;
        int unsigned pos;
        int unsigned n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_token_class = TK_END;
        i_undefined_name = 1'b0;
        sent_count = 0;
        result_count = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        token_taken = 1'b0;
        timed_out = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        clear_stack();

        // lone end is accepted
        add_token(TK_END, 1'b0);
        // a*b/c+d-e<f
        add_token(TK_OPND, 1'b0);
        add_token(TK_MUL, 1'b1);
        add_token(TK_OPND, 1'b0);
        add_token(TK_DIV, 1'b0);
        add_token(TK_OPND, 1'b0);
        add_token(TK_ADD, 1'b1);
        add_token(TK_OPND, 1'b0);
        add_token(TK_SUB, 1'b0);
        add_token(TK_OPND, 1'b0);
        add_token(TK_LT, 1'b0);
        add_token(TK_OPND, 1'b0);
        add_token(TK_END, 1'b0);
        // (a)<=b
        add_token(TK_LPAR, 1'b0);
        add_token(TK_OPND, 1'b0);
        add_token(TK_RPAR, 1'b1);
        add_token(TK_LE, 1'b0);
        add_token(TK_OPND, 1'b0);
        add_token(TK_END, 1'b0);
        // classes above end behave as end
        add_token(TK_SPARE0, 1'b1);
        add_token(TK_SPARE1, 1'b0);
        // undeclared operand, then two operands in a row
        add_token(TK_OPND, 1'b1);
        add_token(TK_OPND, 1'b0);
        add_token(TK_OPND, 1'b0);

        while (token_queue.size() < TOTAL_TOKENS) begin
            sel = $urandom_range(99);
            start = token_queue.size();
            if (sel < 69) begin
                add_expression($urandom_range(4), $urandom_range(12, 1));
            end else if (sel < 72) begin
                // deep nesting, which overflows the stack at the deepest draws
                n = $urandom_range(16, 12);
                repeat (n) add_token(TK_LPAR, $urandom_range(1));
                add_token(TK_OPND, 1'b0);
                repeat (n) add_token(TK_RPAR, $urandom_range(1));
                add_token(TK_END, 1'b0);
            end else if (sel < 86) begin
                add_expression($urandom_range(3), $urandom_range(8, 1));
                pos = $urandom_range(token_queue.size() - 1, start);
                if ($urandom_range(1)) begin
                    token_queue[pos].cls = $urandom_range(15);
                end else begin
                    token_queue.delete(pos);
                end
            end else begin
                repeat ($urandom_range(6, 1)) add_token($urandom_range(15), $urandom_range(1));
            end
        end
        total_tokens = token_queue.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out &&
               (token_queue.size() > 0 || i_valid || expected_results.size() > 0)) begin
            @(posedge i_clk);
        end
        if (!timed_out) repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (timed_out) $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("%0d tokens, %0d results: %0d reductions, %0d shifts, %0d accepted",
                 sent_count, result_count, kind_seen[KIND_REDUCE], kind_seen[KIND_SHIFT],
                 kind_seen[KIND_ACCEPT]);
        $display("%0d syntax, %0d undefined, %0d overflow; %0d mismatches, %0d missing",
                 kind_seen[KIND_SYNTAX], kind_seen[KIND_UNDEF], kind_seen[KIND_OVERFLOW],
                 mismatch_count, expected_results.size());
        if (!timed_out && mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/opp_pkg.sv
hw/rtl/opp_stack_ram.sv
hw/rtl/opp_ctrl.sv
hw/rtl/operator_precedence_expr_parser.sv
hw/rtl/opp_checker.sv
dv/tb_top.sv
